/* design/ncdf_pkg.sv */
// Shared constants and types for the normal CDF approximation pipeline.
package ncdf_pkg;

   localparam int QB = 30;

   localparam logic [27:0] COEF_P       = 28'd248723596;
   localparam logic [28:0] INV_SQRT_2PI = 29'd428361011;
   localparam logic [30:0] LOG2_E       = 31'd1549082005;
   localparam logic [29:0] LN_2         = 30'd744261118;

   localparam logic signed [32:0] COEF_B5 = 33'sd1428371292;

   localparam logic signed [32:0] POLY_ADD [5] = '{
      -33'sd1955558716,
      33'sd1912847369,
      -33'sd382857446,
      33'sd342933307,
      33'sd0
   };

   typedef struct packed {
      logic bad;
      logic pos;
   } ncdf_flags_type;

endpackage

/* design/normal_cdf_approx.sv */
// Normal CDF, Abramowitz-Stegun 26.2.17, fully pipelined fixed-point datapath.
// Throughput: one beat per cycle while the skid register is empty (a full skid
// stalls every stage); the two restoring dividers and the series stages are each one
// register stage per step, all advancing together.
// An output register plus a skid register keep req_ready high while one result waits.
// Reset (synchronous, active high) clears all valid bits; no clearing pass.
module normal_cdf_approx #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_sample_value,
   input  logic signed [23:0] req_mean_value,
   input  logic        [23:0] req_deviation,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [15:0] rsp_probability,
   output logic               rsp_bad_deviation
);

   localparam int QW1 = FRAC_BITS + 4;
   localparam int PW  = 28 + QW1;
   localparam int SQW = 2 * QW1;
   localparam int QT  = 31;
   localparam int SB  = QW1 + 4;
   localparam int SF  = SB + 4;
   localparam int SJ  = SF + 18;
   localparam int ST  = SJ + QT;
   localparam int NST = ST + 12;

   localparam logic [QW1-1:0] XMAX    = {4'b1000, {FRAC_BITS{1'b0}}};
   localparam logic [PW-1:0]  PX_HALF = PW'(1) << (FRAC_BITS - 1);

   logic adv;
   logic pipe_fire;

   logic [NST:1]             v_ff;
   ncdf_pkg::ncdf_flags_type fl_ff [2:NST];
   ncdf_pkg::ncdf_flags_type fl_in;
   logic [NST:SB]            zero_ff;

   // front end
   logic signed [24:0] diff1_ff;
   logic [23:0]        dev1_ff;
   logic [24:0]        ax2_ff;
   logic [24:0]        ax2_in;
   logic [23:0]        dev2_ff;
   logic [23:0]        rem3_ff;
   logic [QW1-1:0]     bits3_ff;
   logic [23:0]        dev3_ff;
   logic               ovf3_ff;

   // first divider
   logic [23:0]    d1_rem_ff  [1:QW1];
   logic [QW1-1:0] d1_bits_ff [1:QW1];
   logic [QW1-1:0] d1_quo_ff  [1:QW1];
   logic [23:0]    d1_dev_ff  [1:QW1];
   logic           d1_ovf_ff  [1:QW1];

   logic [QW1-1:0] xq_in;
   logic [QW1-1:0] xq_ff;
   logic [PW-1:0]  pxq_ff;
   logic [SQW-1:0] sq_ff;
   logic [31:0]    denom_d_ff;
   logic [35:0]    u_d_ff;
   logic [35:0]    u_in;
   logic [PW-1:0]  px_round;
   logic [36:0]    v_hi;
   logic [60:0]    v_lo;
   logic [35:0]    v_e_ff;
   logic [31:0]    denom_e_ff;
   logic [59:0]    w_prod;
   logic [29:0]    w_f_ff;
   logic [5:0]     k_f_ff;
   logic [31:0]    denom_f_ff;

   // series for exp
   logic [30:0] h_val_ff [1:16];
   logic [29:0] h_w_ff   [1:16];
   logic [5:0]  h_k_ff   [1:16];
   logic [31:0] h_den_ff [1:16];

   logic [30:0] es_ff;
   logic [31:0] den_i_ff;
   logic [60:0] dens_prod;
   logic [28:0] dens_j_ff;
   logic [31:0] den_j_ff;

   // second divider
   logic [31:0]   t_rem_ff  [1:QT];
   logic [QT-1:0] t_bits_ff [1:QT];
   logic [QT-1:0] t_quo_ff  [1:QT];
   logic [31:0]   t_den_ff  [1:QT];
   logic [28:0]   t_dens_ff [1:QT];

   // polynomial
   logic [32:0] p_val_ff  [1:10];
   logic [30:0] p_t_ff    [1:10];
   logic [28:0] p_dens_ff [1:10];

   logic signed [32:0] acc5;
   logic        [31:0] acc5_mag;
   logic        [60:0] tail_prod;
   logic               qa_neg_ff;
   logic        [30:0] qa_tp_ff;
   logic        [31:0] tail_rnd;
   logic        [15:0] tail_ff;
   logic        [15:0] prob_in;

   logic        rsp_valid_ff;
   logic [15:0] rsp_prob_ff;
   logic        rsp_bad_ff;
   logic        skid_valid_ff;
   logic [15:0] skid_prob_ff;
   logic        skid_bad_ff;

   assign adv       = !skid_valid_ff;
   assign req_ready = adv;
   assign pipe_fire = v_ff[NST] && adv;

   // valid and flag lines
   assign fl_in.bad = (dev1_ff == '0);
   assign fl_in.pos = !diff1_ff[24] && (diff1_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NST-1:1], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fl_ff[2] <= fl_in;
         for (int s = 2; s < NST; s++) begin
            fl_ff[s+1] <= fl_ff[s];
         end
         zero_ff <= {zero_ff[NST-1:SB], (xq_in == '0)};
      end
   end

   // standardize: difference, magnitude, range check
   assign ax2_in = diff1_ff[24] ? 25'(-diff1_ff) : 25'(diff1_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         diff1_ff <= {req_sample_value[23], req_sample_value}
                     - {req_mean_value[23], req_mean_value};
         dev1_ff  <= req_deviation;
         ax2_ff   <= ax2_in;
         dev2_ff  <= dev1_ff;
         ovf3_ff  <= {4'b0, ax2_ff} >= {1'b0, dev2_ff, 4'b0};
         rem3_ff  <= {3'b0, ax2_ff[24:4]};
         bits3_ff <= {ax2_ff[3:0], {FRAC_BITS{1'b0}}};
         dev3_ff  <= dev2_ff;
      end
   end

   // |x| = (|diff| << FRAC_BITS) / deviation, one quotient bit per stage
   for (genvar i = 0; i < QW1; i++) begin : g_d1
      logic [23:0]    rem_s;
      logic [QW1-1:0] bits_s;
      logic [QW1-1:0] quo_s;
      logic [23:0]    dev_s;
      logic           ovf_s;
      logic [24:0]    rs;
      logic           ge;
      if (i == 0) begin : g_src
         assign rem_s  = rem3_ff;
         assign bits_s = bits3_ff;
         assign quo_s  = '0;
         assign dev_s  = dev3_ff;
         assign ovf_s  = ovf3_ff;
      end else begin : g_src
         assign rem_s  = d1_rem_ff[i];
         assign bits_s = d1_bits_ff[i];
         assign quo_s  = d1_quo_ff[i];
         assign dev_s  = d1_dev_ff[i];
         assign ovf_s  = d1_ovf_ff[i];
      end
      assign rs = {rem_s, bits_s[QW1-1]};
      assign ge = rs >= {1'b0, dev_s};
      always_ff @(posedge clock) begin
         if (adv) begin
            d1_rem_ff[i+1]  <= ge ? 24'(rs - {1'b0, dev_s}) : rs[23:0];
            d1_bits_ff[i+1] <= {bits_s[QW1-2:0], 1'b0};
            d1_quo_ff[i+1]  <= {quo_s[QW1-2:0], ge};
            d1_dev_ff[i+1]  <= dev_s;
            d1_ovf_ff[i+1]  <= ovf_s;
         end
      end
   end

   assign xq_in = (d1_ovf_ff[QW1] || (d1_quo_ff[QW1] > XMAX)) ? XMAX : d1_quo_ff[QW1];

   // u = x*x/2 in Q30
   if (2 * FRAC_BITS >= 30) begin : g_u
      logic [SQW:0] sq_rnd;
      assign sq_rnd = {1'b0, sq_ff} + ((SQW+1)'(1) << (2 * FRAC_BITS - 30));
      assign u_in   = 36'(sq_rnd >> (2 * FRAC_BITS - 29));
   end else begin : g_u
      assign u_in = 36'(36'(sq_ff) << (29 - 2 * FRAC_BITS));
   end

   assign px_round = (pxq_ff + PX_HALF) >> FRAC_BITS;
   assign v_hi     = 37'(u_d_ff[35:30]) * 37'(ncdf_pkg::LOG2_E);
   assign v_lo     = 61'(u_d_ff[29:0]) * 61'(ncdf_pkg::LOG2_E) + (61'(1) << 29);
   assign w_prod   = 60'(v_e_ff[29:0]) * 60'(ncdf_pkg::LN_2) + (60'(1) << 29);

   always_ff @(posedge clock) begin
      if (adv) begin
         xq_ff      <= xq_in;
         pxq_ff     <= PW'(ncdf_pkg::COEF_P) * PW'(xq_ff);
         sq_ff      <= SQW'(xq_ff) * SQW'(xq_ff);
         denom_d_ff <= (32'(1) << ncdf_pkg::QB) + 32'(px_round);
         u_d_ff     <= u_in;
         v_e_ff     <= 36'(v_hi) + 36'(v_lo[60:30]);
         denom_e_ff <= denom_d_ff;
         w_f_ff     <= w_prod[59:30];
         k_f_ff     <= v_e_ff[35:30];
         denom_f_ff <= denom_e_ff;
      end
   end

   // exp(-w) by Horner, e = 1 - w*e/n for n = 8 down to 1
   for (genvar m = 0; m < 16; m++) begin : g_exp
      logic [30:0] val_s;
      logic [29:0] w_s;
      logic [5:0]  k_s;
      logic [31:0] den_s;
      logic [30:0] val_nx;
      if (m == 0) begin : g_src
         assign val_s = 31'(1) << ncdf_pkg::QB;
         assign w_s   = w_f_ff;
         assign k_s   = k_f_ff;
         assign den_s = denom_f_ff;
      end else begin : g_src
         assign val_s = h_val_ff[m];
         assign w_s   = h_w_ff[m];
         assign k_s   = h_k_ff[m];
         assign den_s = h_den_ff[m];
      end
      if (m % 2 == 0) begin : g_op
         logic [60:0] prod;
         assign prod   = 61'(w_s) * 61'(val_s) + (61'(1) << 29);
         assign val_nx = prod[60:30];
      end else begin : g_op
         localparam int DIVN = 8 - m / 2;
         localparam longint unsigned RECIP = ((64'd1 << 34) + DIVN - 1) / DIVN;
         logic [64:0] prod;
         assign prod   = 65'(val_s[29:0]) * 65'(RECIP[34:0]);
         assign val_nx = (31'(1) << ncdf_pkg::QB) - prod[64:34];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            h_val_ff[m+1] <= val_nx;
            h_w_ff[m+1]   <= w_s;
            h_k_ff[m+1]   <= k_s;
            h_den_ff[m+1] <= den_s;
         end
      end
   end

   assign dens_prod = 61'(ncdf_pkg::INV_SQRT_2PI) * 61'(es_ff) + (61'(1) << 29);

   always_ff @(posedge clock) begin
      if (adv) begin
         es_ff     <= h_val_ff[16] >> h_k_ff[16];
         den_i_ff  <= h_den_ff[16];
         dens_j_ff <= dens_prod[58:30];
         den_j_ff  <= den_i_ff;
      end
   end

   // t = round(2^60 / denom), one quotient bit per stage
   for (genvar i = 0; i < QT; i++) begin : g_t
      logic [31:0]   rem_s;
      logic [QT-1:0] bits_s;
      logic [QT-1:0] quo_s;
      logic [31:0]   den_s;
      logic [28:0]   dens_s;
      logic [32:0]   rs;
      logic          ge;
      if (i == 0) begin : g_src
         assign rem_s  = 32'(1) << (ncdf_pkg::QB - 1);
         assign bits_s = den_j_ff[31:1];
         assign quo_s  = '0;
         assign den_s  = den_j_ff;
         assign dens_s = dens_j_ff;
      end else begin : g_src
         assign rem_s  = t_rem_ff[i];
         assign bits_s = t_bits_ff[i];
         assign quo_s  = t_quo_ff[i];
         assign den_s  = t_den_ff[i];
         assign dens_s = t_dens_ff[i];
      end
      assign rs = {rem_s, bits_s[QT-1]};
      assign ge = rs >= {1'b0, den_s};
      always_ff @(posedge clock) begin
         if (adv) begin
            t_rem_ff[i+1]  <= ge ? 32'(rs - {1'b0, den_s}) : rs[31:0];
            t_bits_ff[i+1] <= {bits_s[QT-2:0], 1'b0};
            t_quo_ff[i+1]  <= {quo_s[QT-2:0], ge};
            t_den_ff[i+1]  <= den_s;
            t_dens_ff[i+1] <= dens_s;
         end
      end
   end

   // polynomial in t: multiply stage, then add stage
   for (genvar m = 0; m < 10; m++) begin : g_poly
      logic [32:0] val_s;
      logic [30:0] t_s;
      logic [28:0] dens_s;
      logic [32:0] val_nx;
      if (m == 0) begin : g_src
         assign val_s  = ncdf_pkg::COEF_B5;
         assign t_s    = t_quo_ff[QT];
         assign dens_s = t_dens_ff[QT];
      end else begin : g_src
         assign val_s  = p_val_ff[m];
         assign t_s    = p_t_ff[m];
         assign dens_s = p_dens_ff[m];
      end
      if (m % 2 == 0) begin : g_op
         logic        neg;
         logic [31:0] mag;
         logic [62:0] prod;
         assign neg    = val_s[32];
         assign mag    = neg ? 32'(-$signed(val_s)) : val_s[31:0];
         assign prod   = 63'(mag) * 63'(t_s) + (63'(1) << 29);
         assign val_nx = {neg, prod[61:30]};
      end else begin : g_op
         logic signed [33:0] sp;
         assign sp     = val_s[32] ? -$signed({2'b0, val_s[31:0]})
                                   : $signed({2'b0, val_s[31:0]});
         assign val_nx = 33'(34'(ncdf_pkg::POLY_ADD[m/2]) + sp);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            p_val_ff[m+1]  <= val_nx;
            p_t_ff[m+1]    <= t_s;
            p_dens_ff[m+1] <= dens_s;
         end
      end
   end

   // tail = poly * density, round to Q16 and clamp
   assign acc5      = p_val_ff[10];
   assign acc5_mag  = acc5[32] ? 32'(-acc5) : acc5[31:0];
   assign tail_prod = 61'(acc5_mag) * 61'(p_dens_ff[10]) + (61'(1) << 29);
   assign tail_rnd  = 32'(qa_tp_ff) + (32'(1) << 13);

   always_ff @(posedge clock) begin
      if (adv) begin
         qa_neg_ff <= acc5[32];
         qa_tp_ff  <= tail_prod[60:30];
         if (qa_neg_ff) begin
            tail_ff <= '0;
         end else if (tail_rnd[31:30] != '0) begin
            tail_ff <= '1;
         end else begin
            tail_ff <= tail_rnd[29:14];
         end
      end
   end

   always_comb begin
      if (fl_ff[NST].bad) begin
         prob_in = '0;
      end else if (zero_ff[NST]) begin
         prob_in = 16'h8000;
      end else if (fl_ff[NST].pos) begin
         prob_in = (tail_ff == '0) ? 16'hFFFF : 16'(-tail_ff);
      end else begin
         prob_in = tail_ff;
      end
   end

   // output register and skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= pipe_fire;
         end
      end else if (pipe_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_prob_ff <= skid_prob_ff;
            rsp_bad_ff  <= skid_bad_ff;
         end else if (pipe_fire) begin
            rsp_prob_ff <= prob_in;
            rsp_bad_ff  <= fl_ff[NST].bad;
         end
      end
      if (pipe_fire && rsp_valid_ff && !rsp_ready) begin
         skid_prob_ff <= prob_in;
         skid_bad_ff  <= fl_ff[NST].bad;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_probability   = rsp_prob_ff;
   assign rsp_bad_deviation = rsp_bad_ff;

endmodule

/* bench/normal_cdf_approx_tb.sv */
// Self-checking testbench for the normal CDF approximation pipeline.
`timescale 1ns / 1ps

module normal_cdf_approx_tb;

   localparam int FRAC_BITS   = 16;
   localparam int QB          = 30;
   localparam int LATENCY     = FRAC_BITS + 73;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM    = 630;

   localparam longint unsigned QONE  = 64'd1 << QB;
   localparam longint unsigned QHALF = 64'd1 << (QB - 1);
   localparam longint unsigned K_P   = 64'd248723596;
   localparam longint K_B1 = 342933307;
   localparam longint K_B2 = -382857446;
   localparam longint K_B3 = 1912847369;
   localparam longint K_B4 = -1955558716;
   localparam longint K_B5 = 1428371292;
   localparam longint unsigned K_ISQ2PI = 64'd428361011;
   localparam longint unsigned K_LOG2E  = 64'd1549082005;
   localparam longint unsigned K_LN2    = 64'd744261118;
   localparam logic [15:0] PROB_NONE = 16'd0;
   localparam logic [15:0] PROB_HALF = 16'd32768;
   localparam logic [15:0] PROB_SAT  = 16'd65535;

   typedef struct packed {
      logic signed [23:0] sample;
      logic signed [23:0] mean;
      logic        [23:0] dev;
   } cdf_query_type;

   typedef struct packed {
      logic [15:0] prob;
      logic        bad;
   } cdf_answer_type;

   typedef struct {
      cdf_query_type  q;
      logic           known;
      cdf_answer_type ans;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [23:0] req_sample_value = '0;
   logic signed [23:0] req_mean_value = '0;
   logic        [23:0] req_deviation = 24'd1;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic        [15:0] rsp_probability;
   logic               rsp_bad_deviation;

   cdf_answer_type pending_answers[$];
   cdf_query_type  query_queue[$];
   int             error_count = 0;
   int             cycle_count = 0;
   logic           stimulus_done = 1'b0;

   normal_cdf_approx #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_value  (req_sample_value),
      .req_mean_value    (req_mean_value),
      .req_deviation     (req_deviation),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_probability   (rsp_probability),
      .rsp_bad_deviation (rsp_bad_deviation)
   );

   always #6 clock = ~clock;

   function automatic longint round_mul(longint a, longint unsigned b);
      longint unsigned m;
      longint unsigned p;
      m = (a < 0) ? longint'(-a) : a;
      p = (m * b + QHALF) >> QB;
      return (a < 0) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint unsigned decay_exp(longint unsigned u);
      longint unsigned v, k, f, w, e;
      v = (u >> QB) * K_LOG2E + (((u & (QONE - 1)) * K_LOG2E + QHALF) >> QB);
      k = v >> QB;
      f = v & (QONE - 1);
      w = (f * K_LN2 + QHALF) >> QB;
      e = QONE;
      for (int n = 8; n >= 1; n--) begin
         e = QONE - ((w * e + QHALF) >> QB) / n;
      end
      return (k >= 62) ? 64'd0 : (e >> k);
   endfunction

   function automatic cdf_answer_type normal_cdf(cdf_query_type q);
      cdf_answer_type  a;
      longint          diff, acc, tail;
      longint unsigned ax, xq, xw, denom, t, sq, u, dens, tail16;
      a.bad = 1'b0;
      a.prob = PROB_NONE;
      if (q.dev == 0) begin
         a.bad = 1'b1;
         return a;
      end
      diff = longint'(q.sample) - longint'(q.mean);
      ax = (diff < 0) ? longint'(-diff) : diff;
      xq = (ax << FRAC_BITS) / longint'(q.dev);
      if (xq > (64'd8 << FRAC_BITS)) xq = 64'd8 << FRAC_BITS;
      if (xq == 0) begin
         a.prob = PROB_HALF;
         return a;
      end
      xw = xq << (QB - FRAC_BITS);
      denom = QONE + ((K_P * xw + QHALF) >> QB);
      t = ((64'd1 << (2 * QB)) + denom / 2) / denom;
      acc = K_B5;
      acc = K_B4 + round_mul(acc, t);
      acc = K_B3 + round_mul(acc, t);
      acc = K_B2 + round_mul(acc, t);
      acc = K_B1 + round_mul(acc, t);
      acc = round_mul(acc, t);
      sq = xq * xq;
      if (2 * FRAC_BITS >= QB + 1)
         u = (sq + (64'd1 << (2 * FRAC_BITS - QB))) >> (2 * FRAC_BITS - QB + 1);
      else
         u = sq << (QB - 1 - 2 * FRAC_BITS);
      dens = (K_ISQ2PI * decay_exp(u) + QHALF) >> QB;
      tail = round_mul(acc, dens);
      if (tail < 0) tail = 0;
      tail16 = (longint'(tail) + (64'd1 << (QB - 17))) >> (QB - 16);
      if (tail16 > 65535) tail16 = 65535;
      if (diff > 0) begin
         a.prob = (65536 - tail16 > 65535) ? PROB_SAT : 16'(65536 - tail16);
      end else begin
         a.prob = 16'(tail16);
      end
      return a;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   function automatic cdf_query_type random_query();
      cdf_query_type q;
      int            mode;
      logic [23:0]   span;
      mode = $urandom_range(0, 9);
      q.sample = 24'($urandom);
      q.mean = 24'($urandom);
      q.dev = 24'($urandom);
      case (mode)
         0: q.dev = 24'($urandom_range(0, 3));
         1: q.mean = q.sample;
         2: q.mean = q.sample + 24'($urandom_range(0, 255)) - 24'sd128;
         3, 4, 5: begin
            q.dev = 24'($urandom_range(1, 24'hFFFFFF));
            span = 24'((longint'($urandom_range(0, 8 << 16)) * longint'(q.dev)) >> 16);
            q.mean = $urandom_range(0, 1) ? q.sample - span : q.sample + span;
         end
         default: ;
      endcase
      return q;
   endfunction

   // sender: directed table then random beats, in bursts with gaps
   initial begin
      directed_row_type rows[$];
      cdf_query_type    q;
      int               burst;
      int               gap;
      rows = '{
         '{'{24'sd0, 24'sd0, 24'd0}, 1'b1, '{PROB_NONE, 1'b1}},
         '{'{24'sh7FFFFF, 24'sh800000, 24'd0}, 1'b1, '{PROB_NONE, 1'b1}},
         '{'{24'sd65536, 24'sd65536, 24'd65536}, 1'b1, '{PROB_HALF, 1'b0}},
         '{'{24'sd1, 24'sd0, 24'hFFFFFF}, 1'b1, '{PROB_HALF, 1'b0}},
         '{'{24'sh7FFFFF, 24'sh800000, 24'd1}, 1'b1, '{PROB_SAT, 1'b0}},
         '{'{24'sh800000, 24'sh7FFFFF, 24'd1}, 1'b1, '{PROB_NONE, 1'b0}},
         '{'{24'sh7FFFFF, 24'sh7FFFFF, 24'hFFFFFF}, 1'b1, '{PROB_HALF, 1'b0}},
         '{'{24'sh800000, 24'sh800000, 24'd1}, 1'b1, '{PROB_HALF, 1'b0}},
         '{'{24'sd65536, 24'sd0, 24'd65536}, 1'b0, '{PROB_NONE, 1'b0}},
         '{'{-24'sd65536, 24'sd0, 24'd65536}, 1'b0, '{PROB_NONE, 1'b0}},
         '{'{24'sd131072, 24'sd0, 24'd65536}, 1'b0, '{PROB_NONE, 1'b0}},
         '{'{24'sd524288, 24'sd0, 24'd65536}, 1'b0, '{PROB_NONE, 1'b0}},
         '{'{-24'sd524288, 24'sd0, 24'd65536}, 1'b0, '{PROB_NONE, 1'b0}},
         '{'{24'sd600000, 24'sd0, 24'd65536}, 1'b0, '{PROB_NONE, 1'b0}},
         '{'{24'sd1, 24'sd0, 24'd65536}, 1'b0, '{PROB_NONE, 1'b0}},
         '{'{-24'sd1, 24'sd0, 24'd65536}, 1'b0, '{PROB_NONE, 1'b0}},
         '{'{24'sd0, 24'sh7FFFFF, 24'hFFFFFF}, 1'b0, '{PROB_NONE, 1'b0}},
         '{'{24'sh555555, -24'sh2AAAAA, 24'hAAAAAA}, 1'b0, '{PROB_NONE, 1'b0}},
         '{'{-24'sh2AAAAA, 24'sh555555, 24'h555555}, 1'b0, '{PROB_NONE, 1'b0}}
      };
      foreach (rows[i]) query_queue.insert(query_queue.size(), rows[i].q);
      for (int i = 0; i < N_RANDOM; i++) query_queue.insert(query_queue.size(), random_query());
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (query_queue.size() > 0) begin
         burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
         while (burst > 0 && query_queue.size() > 0) begin
            q = query_queue.pop_front();
            req_valid <= 1'b1;
            req_sample_value <= q.sample;
            req_mean_value <= q.mean;
            req_deviation <= q.dev;
            @(posedge clock);
            while (!req_ready) @(posedge clock);
            if (rows.size() > 0) begin
               if (rows[0].known) begin
                  pending_answers.insert(pending_answers.size(), rows[0].ans);
               end else begin
                  pending_answers.insert(pending_answers.size(), normal_cdf(q));
               end
               void'(rows.pop_front());
            end else begin
               pending_answers.insert(pending_answers.size(), normal_cdf(q));
            end
            burst--;
         end
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      stimulus_done <= 1'b1;
   end

   // receiver: stall pattern with calm stretches
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         if ((phase / 200) % 3 == 2) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 99) < 60);
      end
   end

   always @(posedge clock) begin
      cdf_answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected beat", rsp_probability, -1);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_probability !== want.prob)
               report_mismatch("probability", rsp_probability, want.prob);
            if (rsp_bad_deviation !== want.bad)
               report_mismatch("bad_deviation", rsp_bad_deviation, want.bad);
         end
      end
   end

   initial begin
      wait (stimulus_done);
      while (pending_answers.size() > 0 && cycle_count < CYCLE_LIMIT) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0 && pending_answers.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TIMEOUT at cycle %0d", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
